/* sv/tmr_pkg.sv */
// Shared constants, types and codes for the timer task table.
package tmr_pkg;

  localparam int MAX_TASKS = 16;
  localparam int TIME_BITS = 32;
  localparam int ID_BITS   = 32;
  localparam int IDX_BITS  = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_BITS  = $clog2(MAX_TASKS + 1);

  typedef logic [TIME_BITS-1:0] time_t;
  typedef logic [ID_BITS-1:0]   id_t;
  typedef logic [IDX_BITS-1:0]  idx_t;
  typedef logic [CNT_BITS-1:0]  cnt_t;

  typedef enum logic [2:0] {
    REQ_ONCE   = 3'd0,
    REQ_REPEAT = 3'd1,
    REQ_CANCEL = 3'd2,
    REQ_TICK   = 3'd3,
    REQ_CLEAR  = 3'd4
  } req_t;

  typedef enum logic [2:0] {
    RESP_SCHED   = 3'd0,
    RESP_REJECT  = 3'd1,
    RESP_CANCEL  = 3'd2,
    RESP_FIRED   = 3'd3,
    RESP_NONE    = 3'd4,
    RESP_CLEARED = 3'd5
  } resp_t;

  typedef struct packed {
    logic  set;
    logic  upd_due;
    logic  kill;
    logic  kill_all;
    idx_t  idx;
    id_t   id;
    time_t due;
    time_t ival;
    logic  rep;
  } tbl_wr_t;

  typedef struct packed {
    logic  valid;
    time_t due;
    time_t ival;
    logic  rep;
    id_t   id;
  } tbl_rd_t;

endpackage

/* sv/tmr_alu.sv */
// Shared unit: saturating time add, time compare and id compare.
module tmr_alu (
  input  tmr_pkg::time_t a,
  input  tmr_pkg::time_t b,
  input  tmr_pkg::time_t c,
  input  tmr_pkg::id_t   id_a,
  input  tmr_pkg::id_t   id_b,
  output tmr_pkg::time_t sum_sat,
  output logic           a_ge_c,
  output logic           id_eq
);
  import tmr_pkg::*;

  logic [TIME_BITS:0] sum_full;

  assign sum_full = {1'b0, a} + {1'b0, b};
  assign sum_sat  = sum_full[TIME_BITS] ? {TIME_BITS{1'b1}} : sum_full[TIME_BITS-1:0];
  assign a_ge_c   = (a >= c);
  assign id_eq    = (id_a == id_b);

endmodule

/* sv/tmr_table.sv */
// Timer slot storage with valid bits and lowest-free-slot search.
module tmr_table (
  input  logic             clk,
  input  logic             rst_n,
  input  tmr_pkg::idx_t    rd_idx,
  input  tmr_pkg::tbl_wr_t wr,
  output tmr_pkg::tbl_rd_t rd,
  output tmr_pkg::idx_t    free_idx,
  output logic             full
);
  import tmr_pkg::*;

  logic [MAX_TASKS-1:0] valid_r;
  logic [MAX_TASKS-1:0] valid_nxt;
  time_t                due_r  [MAX_TASKS];
  time_t                ival_r [MAX_TASKS];
  logic                 rep_r  [MAX_TASKS];
  id_t                  id_r   [MAX_TASKS];

  always_comb begin
    free_idx = '0;
    full     = 1'b1;
    for (int i = MAX_TASKS - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_idx = idx_t'(i);
        full     = 1'b0;
      end
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    if (wr.kill_all) begin
      valid_nxt = '0;
    end else if (wr.set) begin
      valid_nxt[wr.idx] = 1'b1;
    end else if (wr.kill) begin
      valid_nxt[wr.idx] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.set) begin
      id_r[wr.idx]   <= wr.id;
      due_r[wr.idx]  <= wr.due;
      ival_r[wr.idx] <= wr.ival;
      rep_r[wr.idx]  <= wr.rep;
    end else if (wr.upd_due) begin
      due_r[wr.idx] <= wr.due;
    end
  end

  assign rd.valid = valid_r[rd_idx];
  assign rd.due   = due_r[rd_idx];
  assign rd.ival  = ival_r[rd_idx];
  assign rd.rep   = rep_r[rd_idx];
  assign rd.id    = id_r[rd_idx];

`ifndef ASSERT_OFF
  a_set_free: assert property (@(posedge clk) disable iff (!rst_n)
    wr.set |-> !valid_r[wr.idx])
    else $error("schedule into a live slot");
  a_upd_live: assert property (@(posedge clk) disable iff (!rst_n)
    wr.upd_due |-> valid_r[wr.idx])
    else $error("re-arm of a free slot");
  a_clear_all: assert property (@(posedge clk) disable iff (!rst_n)
    wr.kill_all |=> (valid_r == '0))
    else $error("clear left live slots");
`endif

endmodule

/* sv/timer_task_table.sv */
// Timer task table top level: request sequencer, slot scan and result register.
//
//   channel | direction | handshake             | words
//   in_     | input     | in_valid / in_ready   | one request word
//   out_    | output    | out_valid / out_ready | one or more result words per request
//
// Schedule passes S_SCHED and then S_FIN. Cancel and tick scan all MAX_TASKS slots, one slot per cycle
// through the shared compare/add unit. Clear and unknown requests go straight to S_FIN.
// A tick holds its scan while a fired word waits on out_ready.
// Reset (rst_n low, synchronous) frees all slots, sets the next id to one
// and the last tick time to zero.
module timer_task_table (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_req_type,
  input  logic [31:0] in_delay_ticks,
  input  logic [31:0] in_interval_ticks,
  input  logic [31:0] in_cancel_id,
  input  logic [31:0] in_current_time,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_resp_kind,
  output logic [31:0] out_id,
  output logic        out_found,
  output logic [4:0]  out_task_count,
  output logic        out_last
);
  import tmr_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCHED,
    S_CANCEL,
    S_TICK,
    S_FIN
  } state_t;

  state_t  state_r, state_nxt;
  idx_t    idx_r, idx_nxt;
  logic    rep_r, rep_nxt;
  time_t   delay_r, delay_nxt;
  time_t   ival_r, ival_nxt;
  id_t     cid_r, cid_nxt;
  time_t   now_r, now_nxt;
  time_t   last_tick_r, last_tick_nxt;
  id_t     next_id_r, next_id_nxt;
  cnt_t    live_count_r, live_count_nxt;
  logic    hit_r, hit_nxt;
  resp_t   fin_kind_r, fin_kind_nxt;
  id_t     fin_id_r, fin_id_nxt;
  logic    pend_v_r, pend_v_nxt;
  id_t     pend_id_r, pend_id_nxt;
  cnt_t    pend_cnt_r, pend_cnt_nxt;
  logic    out_valid_r, out_valid_nxt;
  resp_t   out_kind_r, out_kind_nxt;
  id_t     out_id_r, out_id_nxt;
  logic    out_found_r, out_found_nxt;
  cnt_t    out_cnt_r, out_cnt_nxt;
  logic    out_last_r, out_last_nxt;

  tbl_wr_t tbl_wr;
  tbl_rd_t tbl_rd;
  idx_t    free_idx;
  logic    full;
  time_t   alu_a, alu_b, alu_sum;
  logic    alu_ge, alu_eq;
  logic    push_ok;
  logic    fire;
  id_t     id_inc;

  tmr_table u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_idx   (idx_r),
    .wr       (tbl_wr),
    .rd       (tbl_rd),
    .free_idx (free_idx),
    .full     (full)
  );

  assign alu_a = (state_r == S_SCHED) ? last_tick_r : now_r;
  assign alu_b = (state_r == S_SCHED) ? delay_r : tbl_rd.ival;

  tmr_alu u_alu (
    .a       (alu_a),
    .b       (alu_b),
    .c       (tbl_rd.due),
    .id_a    (tbl_rd.id),
    .id_b    (cid_r),
    .sum_sat (alu_sum),
    .a_ge_c  (alu_ge),
    .id_eq   (alu_eq)
  );

  assign push_ok = !out_valid_r || out_ready;
  assign fire    = tbl_rd.valid && alu_ge;
  assign id_inc  = next_id_r + id_t'(1);

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    rep_nxt        = rep_r;
    delay_nxt      = delay_r;
    ival_nxt       = ival_r;
    cid_nxt        = cid_r;
    now_nxt        = now_r;
    last_tick_nxt  = last_tick_r;
    next_id_nxt    = next_id_r;
    live_count_nxt = live_count_r;
    hit_nxt        = hit_r;
    fin_kind_nxt   = fin_kind_r;
    fin_id_nxt     = fin_id_r;
    pend_v_nxt     = pend_v_r;
    pend_id_nxt    = pend_id_r;
    pend_cnt_nxt   = pend_cnt_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_kind_nxt   = out_kind_r;
    out_id_nxt     = out_id_r;
    out_found_nxt  = out_found_r;
    out_cnt_nxt    = out_cnt_r;
    out_last_nxt   = out_last_r;
    tbl_wr         = '0;
    tbl_wr.idx     = idx_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          rep_nxt    = (in_req_type == REQ_REPEAT);
          delay_nxt  = time_t'(in_delay_ticks);
          ival_nxt   = time_t'(in_interval_ticks);
          cid_nxt    = in_cancel_id;
          now_nxt    = time_t'(in_current_time);
          hit_nxt    = 1'b0;
          pend_v_nxt = 1'b0;
          fin_id_nxt = '0;
          case (in_req_type)
            REQ_ONCE, REQ_REPEAT: begin
              state_nxt = S_SCHED;
            end
            REQ_CANCEL: begin
              idx_nxt   = '0;
              state_nxt = S_CANCEL;
            end
            REQ_TICK: begin
              idx_nxt       = idx_t'(MAX_TASKS - 1);
              last_tick_nxt = time_t'(in_current_time);
              fin_kind_nxt  = RESP_NONE;
              state_nxt     = S_TICK;
            end
            REQ_CLEAR: begin
              tbl_wr.kill_all = 1'b1;
              live_count_nxt  = '0;
              fin_kind_nxt    = RESP_CLEARED;
              state_nxt       = S_FIN;
            end
            default: begin
              fin_kind_nxt = RESP_REJECT;
              state_nxt    = S_FIN;
            end
          endcase
        end
      end
      S_SCHED: begin
        if (full || (rep_r && (ival_r == '0))) begin
          fin_kind_nxt = RESP_REJECT;
        end else begin
          tbl_wr.set     = 1'b1;
          tbl_wr.idx     = free_idx;
          tbl_wr.id      = next_id_r;
          tbl_wr.due     = alu_sum;
          tbl_wr.ival    = ival_r;
          tbl_wr.rep     = rep_r;
          live_count_nxt = live_count_r + cnt_t'(1);
          fin_kind_nxt   = RESP_SCHED;
          fin_id_nxt     = next_id_r;
          next_id_nxt    = (id_inc == '0) ? id_t'(1) : id_inc;
        end
        state_nxt = S_FIN;
      end
      S_CANCEL: begin
        if (tbl_rd.valid && alu_eq) begin
          tbl_wr.kill    = 1'b1;
          live_count_nxt = live_count_r - cnt_t'(1);
          hit_nxt        = 1'b1;
        end
        if (idx_r == idx_t'(MAX_TASKS - 1)) begin
          fin_kind_nxt = RESP_CANCEL;
          fin_id_nxt   = cid_r;
          state_nxt    = S_FIN;
        end else begin
          idx_nxt = idx_r + idx_t'(1);
        end
      end
      S_TICK: begin
        if (!(fire && pend_v_r && !push_ok)) begin
          if (fire) begin
            if (tbl_rd.rep) begin
              tbl_wr.upd_due = 1'b1;
              tbl_wr.due     = alu_sum;
              pend_cnt_nxt   = live_count_r;
            end else begin
              tbl_wr.kill    = 1'b1;
              live_count_nxt = live_count_r - cnt_t'(1);
              pend_cnt_nxt   = live_count_r - cnt_t'(1);
            end
            if (pend_v_r) begin
              out_valid_nxt = 1'b1;
              out_kind_nxt  = RESP_FIRED;
              out_id_nxt    = pend_id_r;
              out_found_nxt = 1'b0;
              out_cnt_nxt   = pend_cnt_r;
              out_last_nxt  = 1'b0;
            end
            pend_v_nxt  = 1'b1;
            pend_id_nxt = tbl_rd.id;
          end
          if (idx_r == '0) begin
            state_nxt = S_FIN;
          end else begin
            idx_nxt = idx_r - idx_t'(1);
          end
        end
      end
      S_FIN: begin
        if (push_ok) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = pend_v_r ? RESP_FIRED : fin_kind_r;
          out_id_nxt    = pend_v_r ? pend_id_r : fin_id_r;
          out_found_nxt = hit_r;
          out_cnt_nxt   = pend_v_r ? pend_cnt_r : live_count_r;
          out_last_nxt  = 1'b1;
          pend_v_nxt    = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      idx_r        <= '0;
      last_tick_r  <= '0;
      next_id_r    <= id_t'(1);
      live_count_r <= '0;
      hit_r        <= 1'b0;
      fin_kind_r   <= RESP_REJECT;
      pend_v_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      idx_r        <= idx_nxt;
      last_tick_r  <= last_tick_nxt;
      next_id_r    <= next_id_nxt;
      live_count_r <= live_count_nxt;
      hit_r        <= hit_nxt;
      fin_kind_r   <= fin_kind_nxt;
      pend_v_r     <= pend_v_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    rep_r       <= rep_nxt;
    delay_r     <= delay_nxt;
    ival_r      <= ival_nxt;
    cid_r       <= cid_nxt;
    now_r       <= now_nxt;
    fin_id_r    <= fin_id_nxt;
    pend_id_r   <= pend_id_nxt;
    pend_cnt_r  <= pend_cnt_nxt;
    out_kind_r  <= out_kind_nxt;
    out_id_r    <= out_id_nxt;
    out_found_r <= out_found_nxt;
    out_cnt_r   <= out_cnt_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign in_ready       = (state_r == S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_resp_kind  = out_kind_r;
  assign out_id         = 32'(out_id_r);
  assign out_found      = out_found_r;
  assign out_task_count = 5'(out_cnt_r);
  assign out_last       = out_last_r;

`ifndef ASSERT_OFF
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    live_count_r <= cnt_t'(MAX_TASKS))
    else $error("live count above table size");
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("ready right after accepting a request");
  a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !pend_v_r)
    else $error("fired word left pending while idle");
`endif

endmodule
